// ===== rtl/sadl_pkg.sv =====
// Package for the sensor average and dead-zone LED block.
// Holds the field widths and the fixed constants for the percent and ratio tests.
// No dependencies.
package sadl_pkg;

  // Field widths.
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned PCT_W    = 7;

  // Light percent mapping: range 100 to 1000, clamped near both ends.
  localparam int unsigned LIGHT_FLOOR = 100;
  localparam int unsigned PCT_LOW     = 5;
  localparam int unsigned PCT_HIGH    = 95;
  localparam int unsigned PCT_FULL    = 100;

  // (x * 100) / 900 equals x / 9. That is done as a multiply by a rounded-up
  // reciprocal, which is exact for every x below 2**SAMPLE_W.
  localparam int unsigned DIV9_SHIFT = SAMPLE_W + 4;
  localparam int unsigned DIV9_MULT  = ((1 << DIV9_SHIFT) + 8) / 9;
  localparam int unsigned DIV9_MW    = $clog2(DIV9_MULT + 1);

  // Ratio tests as integer cross products (average side, baseline side).
  localparam int unsigned LIGHT_ON_A  = 5;   // 5a >= 9b
  localparam int unsigned LIGHT_ON_B  = 9;
  localparam int unsigned LIGHT_OFF_A = 5;   // 5a <= 6b
  localparam int unsigned LIGHT_OFF_B = 6;
  localparam int unsigned TOUCH_OFF_A = 10;  // 10a >= 9b
  localparam int unsigned TOUCH_OFF_B = 9;
  localparam int unsigned TOUCH_ON_A  = 10;  // 10a <= 7b
  localparam int unsigned TOUCH_ON_B  = 7;
  localparam int unsigned TEMP_ON_A   = 100; // 100a > 103b
  localparam int unsigned TEMP_ON_B   = 103;

  // Widths of the cross products.
  localparam int unsigned LT_PROD_W = 14;
  localparam int unsigned TP_PROD_W = 17;

endpackage

// ===== rtl/sadl_if.sv =====
// Handshake channels of the sensor average block: sample beats in, result beats out.
// Depends on sadl_pkg for the field widths.
interface sadl_in_if;
  logic                              valid;
  logic                              ready;
  logic [sadl_pkg::SAMPLE_W-1:0]     light_sample;
  logic [sadl_pkg::SAMPLE_W-1:0]     touch_sample;
  logic [sadl_pkg::SAMPLE_W-1:0]     temp_sample;

  modport source (output valid, output light_sample, output touch_sample,
                  output temp_sample, input ready);
  modport sink   (input valid, input light_sample, input touch_sample,
                  input temp_sample, output ready);
endinterface

interface sadl_out_if;
  logic                              valid;
  logic                              ready;
  logic [sadl_pkg::PCT_W-1:0]        dim_percent;
  logic                              light_led;
  logic                              temp_led;
  logic                              touch_led;
  logic [sadl_pkg::SAMPLE_W-1:0]     light_average;
  logic [sadl_pkg::SAMPLE_W-1:0]     touch_average;
  logic [sadl_pkg::SAMPLE_W-1:0]     temp_average;

  modport source (output valid, output dim_percent, output light_led,
                  output temp_led, output touch_led, output light_average,
                  output touch_average, output temp_average, input ready);
  modport sink   (input valid, input dim_percent, input light_led,
                  input temp_led, input touch_led, input light_average,
                  input touch_average, input temp_average, output ready);
endinterface

// ===== rtl/sensor_average_deadzone_leds_core.sv =====
// Sensor average and dead-zone LED core: one sample triple per beat.
// A window's result passes the total, average and result registers (sum, divide, decide).
// Only windows after the first give a result; the first latches the baselines.
// Throughput is one sample beat per cycle while the result side keeps up.
// Asynchronous active-low reset clears counts, sums, baselines and LED states.
// Depends on sadl_pkg, sadl_if, sadl_accum, sadl_avg and sadl_decide.
module sensor_average_deadzone_leds_core #(
  parameter int unsigned SAMPLES_PER_AVERAGE = 5
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sadl_in_if.sink    sample_i,
  sadl_out_if.source result_o
);

  // The sums are sized to hold a full window of maximum samples, so they never
  // wrap; the count only has to reach the window length minus one.
  localparam int unsigned N     = SAMPLES_PER_AVERAGE;
  localparam int unsigned SUM_W = $clog2(N * ((1 << sadl_pkg::SAMPLE_W) - 1) + 1);
  localparam int unsigned CNT_W = (N > 1) ? $clog2(N) : 1;

  logic                          beat;
  logic                          tot_valid, avg_ready;
  logic [SUM_W-1:0]              light_tot, touch_tot, temp_tot;
  logic                          avg_valid, dec_free;
  logic [sadl_pkg::SAMPLE_W-1:0] light_avg, touch_avg, temp_avg;

  // A sample beat is taken whenever the window-total register is empty or will
  // move on in this cycle. Beats that do not close a window only touch the sums,
  // but gating every beat the same way keeps the ready term short.
  assign sample_i.ready = !tot_valid || avg_ready;
  assign beat           = sample_i.valid && sample_i.ready;

  // Stage one: running sums. The beat that closes a window stores the full
  // window totals and restarts the sums from zero.
  sadl_accum #(
    .N     (N),
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .light_i     (sample_i.light_sample),
    .touch_i     (sample_i.touch_sample),
    .temp_i      (sample_i.temp_sample),
    .adv_i       (avg_ready),
    .valid_o     (tot_valid),
    .light_tot_o (light_tot),
    .touch_tot_o (touch_tot),
    .temp_tot_o  (temp_tot)
  );

  // Stage two: truncating division by the window length, done as a multiply by
  // a rounded-up reciprocal, with the three averages registered.
  sadl_avg #(
    .N     (N),
    .SUM_W (SUM_W)
  ) u_avg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (tot_valid),
    .adv_i       (dec_free),
    .light_tot_i (light_tot),
    .touch_tot_i (touch_tot),
    .temp_tot_i  (temp_tot),
    .ready_o     (avg_ready),
    .valid_o     (avg_valid),
    .light_avg_o (light_avg),
    .touch_avg_o (touch_avg),
    .temp_avg_o  (temp_avg)
  );

  // Stage three: the first average sets the baselines and is dropped. Later
  // averages run the cross-product ratio tests, update the light and touch
  // dead-zone states and fill the result register, which holds a result until
  // the sink takes it; the earlier stages go on only until their registers fill.
  sadl_decide u_decide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (avg_valid),
    .light_avg_i (light_avg),
    .touch_avg_i (touch_avg),
    .temp_avg_i  (temp_avg),
    .free_o      (dec_free),
    .result_o    (result_o)
  );

endmodule

// ===== rtl/sadl_accum.sv =====
// Window accumulator: running sums of the three channels and the window count.
// Depends on sadl_pkg for the sample width.
module sadl_accum #(
  parameter int unsigned N     = 5,
  parameter int unsigned SUM_W = 13,
  parameter int unsigned CNT_W = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          beat_i,
  input  logic [sadl_pkg::SAMPLE_W-1:0] light_i,
  input  logic [sadl_pkg::SAMPLE_W-1:0] touch_i,
  input  logic [sadl_pkg::SAMPLE_W-1:0] temp_i,
  input  logic                          adv_i,
  output logic                          valid_o,
  output logic [SUM_W-1:0]              light_tot_o,
  output logic [SUM_W-1:0]              touch_tot_o,
  output logic [SUM_W-1:0]              temp_tot_o
);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0] light_sum_q, light_sum_d, touch_sum_q, touch_sum_d;
  logic [SUM_W-1:0] temp_sum_q, temp_sum_d;
  logic [SUM_W-1:0] light_add, touch_add, temp_add;
  logic [SUM_W-1:0] light_tot_q, touch_tot_q, temp_tot_q;
  logic             valid_q, valid_d;
  logic             last;

  assign light_add = light_sum_q + SUM_W'(light_i);
  assign touch_add = touch_sum_q + SUM_W'(touch_i);
  assign temp_add  = temp_sum_q + SUM_W'(temp_i);
  assign last      = (cnt_q == CNT_W'(N - 1));

  always_comb begin
    cnt_d       = cnt_q;
    light_sum_d = light_sum_q;
    touch_sum_d = touch_sum_q;
    temp_sum_d  = temp_sum_q;
    valid_d     = valid_q && !adv_i;
    if (beat_i) begin
      if (last) begin
        cnt_d       = '0;
        light_sum_d = '0;
        touch_sum_d = '0;
        temp_sum_d  = '0;
        valid_d     = 1'b1;
      end else begin
        cnt_d       = cnt_q + CNT_W'(1);
        light_sum_d = light_add;
        touch_sum_d = touch_add;
        temp_sum_d  = temp_add;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      light_sum_q <= '0;
      touch_sum_q <= '0;
      temp_sum_q  <= '0;
      valid_q     <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      light_sum_q <= light_sum_d;
      touch_sum_q <= touch_sum_d;
      temp_sum_q  <= temp_sum_d;
      valid_q     <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat_i && last) begin
      light_tot_q <= light_add;
      touch_tot_q <= touch_add;
      temp_tot_q  <= temp_add;
    end
  end

  assign valid_o     = valid_q;
  assign light_tot_o = light_tot_q;
  assign touch_tot_o = touch_tot_q;
  assign temp_tot_o  = temp_tot_q;

endmodule

// ===== rtl/sadl_avg.sv =====
// Averaging stage: divides the window totals by the window length with a
// reciprocal multiply. Depends on sadl_pkg for the sample width.
module sadl_avg #(
  parameter int unsigned N     = 5,
  parameter int unsigned SUM_W = 13
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic                          adv_i,
  input  logic [SUM_W-1:0]              light_tot_i,
  input  logic [SUM_W-1:0]              touch_tot_i,
  input  logic [SUM_W-1:0]              temp_tot_i,
  output logic                          ready_o,
  output logic                          valid_o,
  output logic [sadl_pkg::SAMPLE_W-1:0] light_avg_o,
  output logic [sadl_pkg::SAMPLE_W-1:0] touch_avg_o,
  output logic [sadl_pkg::SAMPLE_W-1:0] temp_avg_o
);

  // Rounded-up reciprocal; exact floor for every total below 2**SUM_W.
  localparam int unsigned SHIFT  = SUM_W + $clog2(N);
  localparam longint unsigned MULT = ((64'd1 << SHIFT) + N - 1) / N;
  localparam int unsigned MULT_W = SHIFT + 1;
  localparam int unsigned PROD_W = SUM_W + MULT_W;

  logic [PROD_W-1:0]             light_prod, touch_prod, temp_prod;
  logic [sadl_pkg::SAMPLE_W-1:0] light_avg_q, touch_avg_q, temp_avg_q;
  logic                          valid_q;
  logic                          take;

  assign light_prod = PROD_W'(light_tot_i) * PROD_W'(MULT_W'(MULT));
  assign touch_prod = PROD_W'(touch_tot_i) * PROD_W'(MULT_W'(MULT));
  assign temp_prod  = PROD_W'(temp_tot_i) * PROD_W'(MULT_W'(MULT));

  assign ready_o = !valid_q || adv_i;
  assign take    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      light_avg_q <= light_prod[SHIFT +: sadl_pkg::SAMPLE_W];
      touch_avg_q <= touch_prod[SHIFT +: sadl_pkg::SAMPLE_W];
      temp_avg_q  <= temp_prod[SHIFT +: sadl_pkg::SAMPLE_W];
    end
  end

  assign valid_o     = valid_q;
  assign light_avg_o = light_avg_q;
  assign touch_avg_o = touch_avg_q;
  assign temp_avg_o  = temp_avg_q;

endmodule

// ===== rtl/sadl_decide.sv =====
// Decision stage: baseline latch, dead-zone LED states, light percent and the
// result register. Depends on sadl_pkg and the sadl_out_if channel.
module sadl_decide (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [sadl_pkg::SAMPLE_W-1:0] light_avg_i,
  input  logic [sadl_pkg::SAMPLE_W-1:0] touch_avg_i,
  input  logic [sadl_pkg::SAMPLE_W-1:0] temp_avg_i,
  output logic                          free_o,
  sadl_out_if.source                    result_o
);

  localparam int unsigned SW  = sadl_pkg::SAMPLE_W;
  localparam int unsigned LW  = sadl_pkg::LT_PROD_W;
  localparam int unsigned TW  = sadl_pkg::TP_PROD_W;
  localparam int unsigned QPW = SW + sadl_pkg::DIV9_MW;

  logic          base_valid_q;
  logic [SW-1:0] light_base_q, touch_base_q, temp_base_q;
  logic          light_st_q, light_st_d, touch_st_q, touch_st_d;
  logic          out_valid_q;
  logic          fire, emit;
  logic          light_on, light_off, touch_on, touch_off, temp_on;
  logic [SW-1:0] light_ofs;
  logic [QPW-1:0] q_prod;
  logic [sadl_pkg::PCT_W-1:0] q, pct;

  logic [sadl_pkg::PCT_W-1:0] pct_q;
  logic          light_led_q, temp_led_q, touch_led_q;
  logic [SW-1:0] light_avg_q, touch_avg_q, temp_avg_q;

  assign free_o = !out_valid_q || result_o.ready;
  assign fire   = valid_i && free_o;
  assign emit   = fire && base_valid_q;

  // Ratio tests against the baselines.
  assign light_on  = LW'(sadl_pkg::LIGHT_ON_A) * LW'(light_avg_i)
                     >= LW'(sadl_pkg::LIGHT_ON_B) * LW'(light_base_q);
  assign light_off = LW'(sadl_pkg::LIGHT_OFF_A) * LW'(light_avg_i)
                     <= LW'(sadl_pkg::LIGHT_OFF_B) * LW'(light_base_q);
  assign touch_off = LW'(sadl_pkg::TOUCH_OFF_A) * LW'(touch_avg_i)
                     >= LW'(sadl_pkg::TOUCH_OFF_B) * LW'(touch_base_q);
  assign touch_on  = LW'(sadl_pkg::TOUCH_ON_A) * LW'(touch_avg_i)
                     <= LW'(sadl_pkg::TOUCH_ON_B) * LW'(touch_base_q);
  assign temp_on   = TW'(sadl_pkg::TEMP_ON_A) * TW'(temp_avg_i)
                     > TW'(sadl_pkg::TEMP_ON_B) * TW'(temp_base_q);

  // The light turns off when both tests hold; the touch LED turns on.
  assign light_st_d = light_off ? 1'b0 : (light_on ? 1'b1 : light_st_q);
  assign touch_st_d = touch_on ? 1'b1 : (touch_off ? 1'b0 : touch_st_q);

  // Light percent: (avg - 100) / 9, with both ends clamped.
  assign light_ofs = light_avg_i - SW'(sadl_pkg::LIGHT_FLOOR);
  assign q_prod    = QPW'(light_ofs) * QPW'(sadl_pkg::DIV9_MULT);
  assign q         = q_prod[sadl_pkg::DIV9_SHIFT +: sadl_pkg::PCT_W];

  always_comb begin
    if (light_avg_i < SW'(sadl_pkg::LIGHT_FLOOR)) begin
      pct = '0;
    end else if (q <= sadl_pkg::PCT_W'(sadl_pkg::PCT_LOW)) begin
      pct = '0;
    end else if (q >= sadl_pkg::PCT_W'(sadl_pkg::PCT_HIGH)) begin
      pct = sadl_pkg::PCT_W'(sadl_pkg::PCT_FULL);
    end else begin
      pct = q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_valid_q <= 1'b0;
      light_base_q <= '0;
      touch_base_q <= '0;
      temp_base_q  <= '0;
      light_st_q   <= 1'b0;
      touch_st_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (fire && !base_valid_q) begin
        base_valid_q <= 1'b1;
        light_base_q <= light_avg_i;
        touch_base_q <= touch_avg_i;
        temp_base_q  <= temp_avg_i;
      end
      if (emit) begin
        light_st_q <= light_st_d;
        touch_st_q <= touch_st_d;
      end
      if (free_o) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      pct_q       <= pct;
      light_led_q <= light_st_d;
      temp_led_q  <= temp_on;
      touch_led_q <= touch_st_d;
      light_avg_q <= light_avg_i;
      touch_avg_q <= touch_avg_i;
      temp_avg_q  <= temp_avg_i;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.dim_percent   = pct_q;
  assign result_o.light_led     = light_led_q;
  assign result_o.temp_led      = temp_led_q;
  assign result_o.touch_led     = touch_led_q;
  assign result_o.light_average = light_avg_q;
  assign result_o.touch_average = touch_avg_q;
  assign result_o.temp_average  = temp_avg_q;

endmodule
